// File: sv/trd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants of the Targa run-length decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

  localparam int unsigned MAX_PIXEL_BYTES = 4;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned RUN_W   = 8;
  localparam int unsigned DIM_W   = 16;
  localparam int unsigned COUNT_W = 32;
  localparam int unsigned BPP_W   = 3;
  localparam int unsigned CIDX_W  = 2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_BYTES_PER_PIXEL = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd2;

  localparam logic [BPP_W-1:0] BPP_RESET = 3'd3;

  // Settings handed from the register block to the decoder.
  typedef struct packed {
    logic [BPP_W-1:0]   bytes_per_pixel;
    logic [COUNT_W-1:0] image_size;
  } trd_cfg_t;

endpackage

// File: sv/trd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_cfg
// Configuration registers and the registered image size product.
// ----------------------------------------------------------------------------
module trd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [trd_pkg::CIDX_W-1:0]  cfg_index_i,
  input  logic [trd_pkg::DIM_W-1:0]   cfg_data_i,
  output trd_pkg::trd_cfg_t           cfg_o,
  output logic                        busy_o
);
  import trd_pkg::*;

  logic [BPP_W-1:0]   bpp_q;
  logic [DIM_W-1:0]   width_q;
  logic [DIM_W-1:0]   height_q;
  logic [COUNT_W-1:0] size_q;
  logic               busy_q;
  logic               cfg_rdy_q;
  logic               wr_en;

  assign cfg_ready_o = cfg_rdy_q;
  assign wr_en       = cfg_valid_i & cfg_rdy_q;

  // Both channels are held off during reset and until the first clock edge after it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q     <= BPP_RESET;
      width_q   <= '0;
      height_q  <= '0;
      size_q    <= '0;
      busy_q    <= 1'b1;
      cfg_rdy_q <= 1'b0;
    end else begin
      cfg_rdy_q <= 1'b1;
      // The product is registered from the dimension registers; busy_q holds
      // off input items until it has caught up.
      size_q <= {{(COUNT_W-DIM_W){1'b0}}, width_q} * {{(COUNT_W-DIM_W){1'b0}}, height_q};
      busy_q <= wr_en;
      if (wr_en) begin
        case (cfg_index_i)
          CFG_BYTES_PER_PIXEL: bpp_q    <= cfg_data_i[BPP_W-1:0];
          CFG_IMAGE_WIDTH:     width_q  <= cfg_data_i;
          CFG_IMAGE_HEIGHT:    height_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign cfg_o.bytes_per_pixel = bpp_q;
  assign cfg_o.image_size      = size_q;
  assign busy_o                = busy_q;

endmodule

// File: sv/trd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_core
// Input register, packet and pixel decode state, and result register.
// ----------------------------------------------------------------------------
module trd_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  trd_pkg::trd_cfg_t            cfg_i,
  input  logic                         hold_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [trd_pkg::BYTE_W-1:0]   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [trd_pkg::PIXEL_W-1:0]  pixel_value_o,
  output logic [trd_pkg::RUN_W-1:0]    run_length_o,
  output logic                         image_done_o
);
  import trd_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_REPEAT  = 2'd1,
    PH_LITERAL = 2'd2
  } phase_e;

  // Input register.
  logic              in_valid_q;
  logic [BYTE_W-1:0] byte_q;

  // Decode state.
  phase_e             phase_q, phase_d;
  logic [RUN_W-1:0]   left_q, left_d;
  logic [1:0]         idx_q, idx_d;
  logic [PIXEL_W-1:0] asm_q, asm_d;
  logic [COUNT_W-1:0] done_cnt_q, done_cnt_d;

  // Result register.
  logic               out_valid_q;
  logic [PIXEL_W-1:0] value_q, value_d;
  logic [RUN_W-1:0]   run_q, run_d;
  logic               img_done_q, img_done_d;

  logic               fire;
  logic               emit;
  logic [BPP_W-1:0]   pix_size;
  logic [BPP_W-1:0]   idx_inc;
  logic [PIXEL_W-1:0] asm_new;
  logic [RUN_W-1:0]   run_raw;
  logic [RUN_W-1:0]   left_new;
  logic [COUNT_W:0]   sum_ext;
  logic               exhausted;
  logic               size_over;
  logic [COUNT_W-1:0] remaining;

  assign fire       = in_valid_q & (~out_valid_q | out_ready_i);
  assign in_ready_o = (~in_valid_q | fire) & ~hold_i;

  always_comb begin
    if (cfg_i.bytes_per_pixel == '0) begin
      pix_size = 3'd1;
    end else if (cfg_i.bytes_per_pixel > BPP_W'(MAX_PIXEL_BYTES)) begin
      pix_size = BPP_W'(MAX_PIXEL_BYTES);
    end else begin
      pix_size = cfg_i.bytes_per_pixel;
    end
  end

  assign idx_inc = {1'b0, idx_q} + 3'd1;
  assign asm_new = asm_q | ({{(PIXEL_W-BYTE_W){1'b0}}, byte_q} << {idx_q, 3'b000});

  // Image accounting: the run finishes the image when the running count
  // reaches the image size, or when the image is empty or already overrun.
  assign size_over = cfg_i.image_size > done_cnt_q;
  assign remaining = cfg_i.image_size - done_cnt_q;
  assign sum_ext   = {1'b0, done_cnt_q} + {{(COUNT_W+1-RUN_W){1'b0}}, run_raw};
  assign exhausted = ~size_over | (sum_ext >= {1'b0, cfg_i.image_size});

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    idx_d      = idx_q;
    asm_d      = asm_q;
    done_cnt_d = done_cnt_q;
    value_d    = asm_new;
    run_d      = 8'd1;
    img_done_d = 1'b0;
    emit       = 1'b0;
    run_raw    = 8'd1;
    left_new   = left_q - 8'd1;

    case (phase_q)
      PH_REPEAT, PH_LITERAL: begin
        if (idx_inc < pix_size) begin
          idx_d = idx_inc[1:0];
          asm_d = asm_new;
        end else begin
          emit  = 1'b1;
          idx_d = '0;
          asm_d = '0;
          if (phase_q == PH_REPEAT) begin
            run_raw  = (left_q == '0) ? 8'd1 : left_q;
            left_new = '0;
          end
          run_d = run_raw;
          if (exhausted) begin
            if (size_over) begin
              run_d = remaining[RUN_W-1:0];
            end
            done_cnt_d = '0;
            img_done_d = 1'b1;
          end else begin
            done_cnt_d = sum_ext[COUNT_W-1:0];
          end
          left_d = left_new;
          if (exhausted || left_new == '0) begin
            phase_d = PH_HEADER;
            left_d  = '0;
          end
        end
      end
      default: begin
        // Packet header: bit 7 selects a repeat packet.
        left_d  = {1'b0, byte_q[6:0]} + 8'd1;
        idx_d   = '0;
        asm_d   = '0;
        phase_d = byte_q[7] ? PH_REPEAT : PH_LITERAL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      phase_q     <= PH_HEADER;
      left_q      <= '0;
      idx_q       <= '0;
      asm_q       <= '0;
      done_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (fire) begin
        phase_q    <= phase_d;
        left_q     <= left_d;
        idx_q      <= idx_d;
        asm_q      <= asm_d;
        done_cnt_q <= done_cnt_d;
        if (emit) begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
    end
    if (fire && emit) begin
      value_q    <= value_d;
      run_q      <= run_d;
      img_done_q <= img_done_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = value_q;
  assign run_length_o  = run_q;
  assign image_done_o  = img_done_q;

endmodule

// File: sv/tga_rle_run_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_run_decoder
// Run-length decoder for the compressed pixel stream of a Targa image.
// ----------------------------------------------------------------------------
// The input channel takes one byte of the compressed stream per item. Each
// complete pixel leaves on the output channel as one item carrying the pixel
// bytes (first byte in bits 7:0), its run length and an end-of-image flag.
// Header bytes and partial pixel bytes produce no output item.
// A byte is captured in an input register and decoded from there into the
// result register once that register is free. One byte is taken every cycle
// while the output is drained and no configuration write is pending; the
// decode step between the two registers is combinational.
// When the receiver stalls, the result register holds and the byte behind it
// waits in the input register; input ready drops once both are full.
// Configuration writes (index 0 pixel size, 1 width, 2 height) are taken in
// any cycle once reset is over; input ready is low for the cycle after a
// write while the image size product is updated.
// Reset clears all decode state, sets the pixel size to 3 bytes and the
// image dimensions to zero. Input and configuration ready stay low during
// reset and until the first clock edge after it.
// ----------------------------------------------------------------------------
module tga_rle_run_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [trd_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [trd_pkg::DIM_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [trd_pkg::BYTE_W-1:0]   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [trd_pkg::PIXEL_W-1:0]  pixel_value_o,
  output logic [trd_pkg::RUN_W-1:0]    run_length_o,
  output logic                         image_done_o
);
  import trd_pkg::*;

  trd_cfg_t cfg;
  logic     cfg_busy;

  trd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg),
    .busy_o      (cfg_busy)
  );

  trd_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .hold_i        (cfg_busy),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_value_o (pixel_value_o),
    .run_length_o  (run_length_o),
    .image_done_o  (image_done_o)
  );

  // A result never carries an empty or oversized run.
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_length_o != 8'd0))
    else $error("output item with zero run length");

  a_run_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (run_length_o <= 8'd128))
    else $error("output item with run length above 128");

  // The image size product must settle before the next input item.
  a_cfg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> !in_ready_o)
    else $error("input accepted while image size is updating");

endmodule

// File: verif/tga_rle_run_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_rle_run_decoder_tb
// Self-checking testbench for the Targa run-length decoder.
// ----------------------------------------------------------------------------
// A queue of stream bytes feeds a valid/ready driver. Each accepted byte goes
// through a decode model that predicts the pixel runs. A monitor compares
// every output item, field by field, with the oldest predicted run.
// A short directed sequence covers reset settings, empty and clipped images,
// a pixel size change in the middle of a pixel and out-of-range pixel sizes.
// Random phases then follow: well-formed images under changing settings,
// with some noise bytes. Both sides idle at random, and the receiver holds
// off once for a long stretch so that the decoder stalls its input.
// ----------------------------------------------------------------------------
module tga_rle_run_decoder_tb;
  import trd_pkg::*;

  localparam int          CLK_PERIOD   = 8;
  localparam int          TIMEOUT_NS   = 2_000_000;
  localparam int unsigned RANDOM_BYTES = 1400;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned HOLD_AT      = 120;
  localparam int unsigned HOLD_CYCLES  = 200;

  // Index 3 has no register behind it; writes to it are dropped.
  localparam logic [CIDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {
    AWAIT_HEADER   = 2'd0,
    REPEAT_PIXEL   = 2'd1,
    LITERAL_PIXELS = 2'd2
  } decode_phase_e;

  typedef struct packed {
    logic [PIXEL_W-1:0] value;
    logic [RUN_W-1:0]   run;
    logic               done;
  } pixel_run_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_valid   = 1'b0;
  logic [CIDX_W-1:0]   cfg_index   = '0;
  logic [DIM_W-1:0]    cfg_data    = '0;
  logic                in_valid    = 1'b0;
  logic [BYTE_W-1:0]   data_byte   = '0;
  logic                out_ready   = 1'b0;
  logic                cfg_ready_o;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [PIXEL_W-1:0]  pixel_value_o;
  logic [RUN_W-1:0]    run_length_o;
  logic                image_done_o;

  // Decode model state and its copy of the settings.
  logic [BPP_W-1:0]    bpp_reg    = BPP_RESET;
  logic [DIM_W-1:0]    width_reg  = '0;
  logic [DIM_W-1:0]    height_reg = '0;
  decode_phase_e       dec_phase  = AWAIT_HEADER;
  logic [7:0]          pkt_left   = '0;
  logic [2:0]          byte_idx   = '0;
  logic [PIXEL_W-1:0]  pix_accum  = '0;
  logic [COUNT_W-1:0]  img_pixels_done = '0;

  logic [BYTE_W-1:0]   stream_bytes[$];
  pixel_run_t          pending_runs[$];
  int unsigned         bytes_pushed   = 0;
  int unsigned         bytes_accepted = 0;
  int unsigned         runs_seen      = 0;
  int unsigned         hold_left      = 0;
  bit                  hold_done      = 1'b0;
  int unsigned         mismatches     = 0;

  tga_rle_run_decoder dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready),
    .pixel_value_o(pixel_value_o),
    .run_length_o (run_length_o),
    .image_done_o (image_done_o)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // A size of 0 counts as one byte, anything above the maximum as the maximum.
  function automatic int unsigned pixel_bytes(input logic [BPP_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_PIXEL_BYTES) return MAX_PIXEL_BYTES;
    return n;
  endfunction

  // Advances the decode model by one stream byte; returns 1 with the run
  // when the byte completes a pixel.
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output pixel_run_t r);
    logic [COUNT_W-1:0] img_size;
    logic [COUNT_W-1:0] remaining;
    logic [COUNT_W-1:0] run;
    r = '0;
    if (dec_phase != REPEAT_PIXEL && dec_phase != LITERAL_PIXELS) begin
      pkt_left  = {1'b0, b[6:0]} + 8'd1;
      byte_idx  = '0;
      pix_accum = '0;
      dec_phase = b[7] ? REPEAT_PIXEL : LITERAL_PIXELS;
      return 1'b0;
    end
    pix_accum = pix_accum | (PIXEL_W'(b) << (8 * byte_idx[1:0]));
    byte_idx  = byte_idx + 3'd1;
    if (byte_idx < pixel_bytes(bpp_reg)) return 1'b0;
    r.value   = pix_accum;
    byte_idx  = '0;
    pix_accum = '0;
    if (dec_phase == REPEAT_PIXEL) begin
      run      = COUNT_W'(pkt_left);
      pkt_left = '0;
    end else begin
      run      = 1;
      pkt_left = pkt_left - 8'd1;
    end
    // Clip the run to the pixels still missing; an empty or exhausted image
    // passes the run on whole and ends at once.
    img_size  = COUNT_W'(width_reg) * COUNT_W'(height_reg);
    remaining = (img_size > img_pixels_done) ? img_size - img_pixels_done : '0;
    if (remaining == 0 || run >= remaining) begin
      if (remaining != 0) run = remaining;
      img_pixels_done = '0;
      r.done = 1'b1;
    end else begin
      img_pixels_done = img_pixels_done + run;
    end
    if (r.done || pkt_left == 0) begin
      dec_phase = AWAIT_HEADER;
      pkt_left  = '0;
    end
    r.run = run[RUN_W-1:0];
    return 1'b1;
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned sel;
    sel = $urandom_range(19);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2) return DIM_W'($urandom);
    if (sel < 6) return DIM_W'($urandom_range(1, 24));
    return DIM_W'($urandom_range(1, 6));
  endfunction

  task automatic send(input logic [BYTE_W-1:0] b);
    stream_bytes = {stream_bytes, b};
    bytes_pushed++;
  endtask

  // Called only while the decoder is idle; the model takes the value at once.
  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BYTES_PER_PIXEL: bpp_reg    = val[BPP_W-1:0];
      CFG_IMAGE_WIDTH:     width_reg  = val;
      CFG_IMAGE_HEIGHT:    height_reg = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Header bytes and partial pixels give no output item, so the task waits until
  // every byte is accepted and every expected run has arrived, then lets the decoder settle.
  task automatic wait_drained();
    do @(posedge clk);
    while (bytes_accepted != bytes_pushed || pending_runs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Byte driver: predicts on acceptance, then offers the next queued byte.
  always @(posedge clk or negedge rst_n) begin : driver
    pixel_run_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        bytes_accepted++;
        if (decode_byte(data_byte, r)) pending_runs = {pending_runs, r};
      end
      if (!in_valid || in_ready_o) begin
        if (stream_bytes.size() != 0 &&
            ((bytes_accepted >= 600 && bytes_accepted < 800) || $urandom_range(99) >= 33)) begin
          in_valid  <= 1'b1;
          data_byte <= stream_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Run monitor: checks each output item and drives ready.
  always @(posedge clk or negedge rst_n) begin : monitor
    pixel_run_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        runs_seen++;
        if (pending_runs.size() == 0) begin
          $error("unexpected item: pixel_value %h run_length %0d image_done %b",
                 pixel_value_o, run_length_o, image_done_o);
          mismatches++;
        end else begin
          want = pending_runs.pop_front();
          if (pixel_value_o !== want.value) begin
            $error("pixel_value: expected %h, got %h", want.value, pixel_value_o);
            mismatches++;
          end
          if (run_length_o !== want.run) begin
            $error("run_length: expected %0d, got %0d", want.run, run_length_o);
            mismatches++;
          end
          if (image_done_o !== want.done) begin
            $error("image_done: expected %b, got %b", want.done, image_done_o);
            mismatches++;
          end
        end
      end
      if (runs_seen == HOLD_AT && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (runs_seen >= 250 && runs_seen < 330) || $urandom_range(99) >= 33;
      end
    end
  end

  initial begin : stimulus
    int unsigned  goal;
    int unsigned  px_left;
    int unsigned  lim;
    int unsigned  count;
    int unsigned  n_img;
    bit           rep;
    bit           exhausted;
    logic [2:0]   bpp;
    logic [31:0]  img_size;
    logic [31:0]  done_base;

    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: 3-byte pixels and an empty image, so each run ends it.
    send(8'hFF); send(8'h00); send(8'h00); send(8'h00);
    send(8'h00); send(8'hFF); send(8'hFF); send(8'hFF);
    wait_drained();

    // A 2x3 image of 4-byte pixels; the second repeat run gets clipped.
    write_reg(CFG_BYTES_PER_PIXEL, 16'd4);
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_IMAGE_HEIGHT, 16'd3);
    send(8'h83); send(8'h11); send(8'h22); send(8'h33); send(8'h44);
    send(8'h82); send(8'hAA); send(8'hBB); send(8'hCC); send(8'hDD);
    wait_drained();

    // Pixel size drops from 4 to 2 with two bytes already collected.
    send(8'h01); send(8'h5A); send(8'hA5);
    wait_drained();
    write_reg(CFG_BYTES_PER_PIXEL, 16'd2);
    send(8'hC3); send(8'h7E); send(8'h81);
    wait_drained();

    // Image shrinks below the pixels already done; size code 0 acts as 1.
    write_reg(CFG_IMAGE_WIDTH, 16'd1);
    write_reg(CFG_IMAGE_HEIGHT, 16'd1);
    write_reg(CFG_BYTES_PER_PIXEL, 16'hFFF8);
    send(8'h80); send(8'h01);
    wait_drained();

    // Largest image and a size code above the maximum.
    write_reg(CFG_BYTES_PER_PIXEL, 16'd7);
    write_reg(CFG_SPARE, 16'hFFFF);
    write_reg(CFG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    send(8'h7F); send(8'hFE); send(8'hDC); send(8'hBA); send(8'h98);
    wait_drained();

    goal = bytes_pushed + RANDOM_BYTES;
    while (bytes_pushed < goal) begin
      if ($urandom_range(3) != 0) begin
        if ($urandom_range(4) == 0) begin
          bpp = $urandom_range(1) ? 3'd0 : 3'($urandom_range(5, 7));
        end else begin
          bpp = 3'($urandom_range(1, 4));
        end
        write_reg(CFG_BYTES_PER_PIXEL, {13'($urandom), bpp});
      end
      if ($urandom_range(1) != 0) write_reg(CFG_IMAGE_WIDTH, pick_dim());
      if ($urandom_range(1) != 0) write_reg(CFG_IMAGE_HEIGHT, pick_dim());
      if ($urandom_range(15) == 0) write_reg(CFG_SPARE, DIM_W'($urandom));

      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(8, 40)) send(BYTE_W'($urandom));
      end else begin
        img_size  = 32'(width_reg) * 32'(height_reg);
        done_base = img_pixels_done;
        n_img     = $urandom_range(1, 3);
        repeat (n_img) begin
          exhausted = (img_size <= done_base);
          if (exhausted) px_left = $urandom_range(1, 3);
          else if (img_size - done_base > 300) px_left = $urandom_range(20, 300);
          else px_left = img_size - done_base;
          done_base = '0;
          while (px_left != 0) begin
            // A literal packet in an empty image would be cut after its
            // first pixel, so those get repeat packets only.
            rep = exhausted || ($urandom_range(1) != 0);
            lim = rep ? 128 : 12;
            if (lim > px_left) lim = px_left;
            count = $urandom_range(1, lim);
            if ($urandom_range(11) == 0) count = px_left + $urandom_range(1, 4);
            if (count > 128) count = 128;
            send({rep, 7'(count - 1)});
            repeat (pixel_bytes(bpp_reg) * (rep ? 1 : count)) send(BYTE_W'($urandom));
            px_left = (count >= px_left) ? 0 : px_left - count;
          end
        end
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS * 1ns);
    $display("TB_ERROR");
    $finish;
  end

endmodule
